// File: rtl/bcgd_pkg.sv
package bcgd_pkg;

    localparam int TIME_W  = 32;
    localparam int COUNT_W = 8;
    localparam int CFG_W   = 16;
    localparam int KIND_W  = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_W-1:0] MAX_GAP_RESET  = 16'd400;
    localparam logic [CFG_W-1:0] MIN_LONG_RESET = 16'd600;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LONG = 1'd1;

    localparam logic [KIND_W-1:0] EV_PRESSED  = 3'd0;
    localparam logic [KIND_W-1:0] EV_RELEASED = 3'd1;
    localparam logic [KIND_W-1:0] EV_CLICKED  = 3'd2;
    localparam logic [KIND_W-1:0] EV_MULTI    = 3'd3;
    localparam logic [KIND_W-1:0] EV_LONG     = 3'd4;

    typedef enum logic [1:0] {
        CMD_PRESS     = 2'd0,
        CMD_REL_CLICK = 2'd1,
        CMD_REL_LONG  = 2'd2,
        CMD_MULTI     = 2'd3
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t          code;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  held;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: rtl/bcgd_if.sv
interface bcgd_poll_if;
    import bcgd_pkg::*;
    logic              valid;
    logic              ready;
    logic              level;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, level, time_ms, input ready);
    modport sink   (input valid, level, time_ms, output ready);
endinterface

interface bcgd_event_if;
    import bcgd_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [TIME_W-1:0] event_value;
    logic              last;

    modport source (output valid, event_kind, event_value, last, input ready);
    modport sink   (input valid, event_kind, event_value, last, output ready);
endinterface

interface bcgd_cfg_if;
    import bcgd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/bcgd_front.sv
module bcgd_front (
    input  logic               clk,
    input  logic               rst_n,
    bcgd_poll_if.sink          poll,
    bcgd_cfg_if.sink           cfg,
    input  bcgd_pkg::q_status_t q_status,
    output logic               push,
    output bcgd_pkg::cmd_t     push_cmd
);
    import bcgd_pkg::*;

    logic [CFG_W-1:0]   max_gap_reg, max_gap_next;
    logic [CFG_W-1:0]   min_long_reg, min_long_next;
    logic               is_down_reg, is_down_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TIME_W-1:0]  press_stamp_reg, release_stamp_reg;

    logic               accept;
    logic [TIME_W-1:0]  held;
    logic [TIME_W-1:0]  gap;
    logic [COUNT_W-1:0] count_inc;
    logic               set_press, set_release;

    assign cfg.ready  = 1'b1;
    assign poll.ready = !q_status.full;
    assign accept     = poll.valid && poll.ready;

    assign held      = poll.time_ms - press_stamp_reg;
    assign gap       = poll.time_ms - release_stamp_reg;
    assign count_inc = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;

    always_comb
    begin
        max_gap_next  = max_gap_reg;
        min_long_next = min_long_reg;
        if (cfg.valid)
        begin
            if (cfg.index == REG_MAX_GAP)
                max_gap_next = cfg.data;
            if (cfg.index == REG_MIN_LONG)
                min_long_next = cfg.data;
        end
    end

    always_comb
    begin
        is_down_next   = is_down_reg;
        count_next     = count_reg;
        set_press      = 1'b0;
        set_release    = 1'b0;
        push           = 1'b0;
        push_cmd.code  = CMD_PRESS;
        push_cmd.count = count_reg;
        push_cmd.held  = held;
        if (accept)
        begin
            priority if (poll.level && !is_down_reg)
            begin
                is_down_next   = 1'b1;
                count_next     = count_inc;
                set_press      = 1'b1;
                push           = 1'b1;
                push_cmd.count = count_inc;
            end
            else if (!poll.level && is_down_reg)
            begin
                is_down_next = 1'b0;
                set_release  = 1'b1;
                push         = 1'b1;
                if (count_reg == COUNT_W'(1) && held >= TIME_W'(min_long_reg))
                begin
                    push_cmd.code = CMD_REL_LONG;
                    count_next    = '0;
                end
                else
                begin
                    push_cmd.code = CMD_REL_CLICK;
                end
            end
            else if (!is_down_reg && count_reg != '0 && gap >= TIME_W'(max_gap_reg))
            begin
                push          = 1'b1;
                push_cmd.code = CMD_MULTI;
                count_next    = '0;
            end
            else
            begin
                push = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_gap_reg  <= MAX_GAP_RESET;
            min_long_reg <= MIN_LONG_RESET;
            is_down_reg  <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            max_gap_reg  <= max_gap_next;
            min_long_reg <= min_long_next;
            is_down_reg  <= is_down_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (set_press)
            press_stamp_reg <= poll.time_ms;
        if (set_release)
            release_stamp_reg <= poll.time_ms;
    end

endmodule

// File: rtl/bcgd_queue.sv
module bcgd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bcgd_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output bcgd_pkg::cmd_t      head,
    output bcgd_pkg::q_status_t status
);
    import bcgd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: rtl/bcgd_back.sv
module bcgd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  bcgd_pkg::cmd_t      head,
    input  bcgd_pkg::q_status_t q_status,
    output logic                pop,
    bcgd_event_if.source        evt
);
    import bcgd_pkg::*;

    logic              out_valid_reg, out_valid_next;
    logic              phase_reg, phase_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [TIME_W-1:0] value_reg, value_next;
    logic              last_reg, last_next;
    logic              load;
    logic [TIME_W-1:0] count_ext;

    assign load      = !out_valid_reg || evt.ready;
    assign count_ext = {{(TIME_W - COUNT_W){1'b0}}, head.count};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (load)
        begin
            if (phase_reg)
            begin
                // second half of a release
                out_valid_next = 1'b1;
                phase_next     = 1'b0;
                pop            = 1'b1;
                last_next      = 1'b1;
                if (head.code == CMD_REL_LONG)
                begin
                    kind_next  = EV_LONG;
                    value_next = head.held;
                end
                else
                begin
                    kind_next  = EV_CLICKED;
                    value_next = count_ext;
                end
            end
            else if (!q_status.empty)
            begin
                out_valid_next = 1'b1;
                value_next     = count_ext;
                unique case (head.code)
                    CMD_PRESS:
                    begin
                        kind_next = EV_PRESSED;
                        last_next = 1'b1;
                        pop       = 1'b1;
                    end
                    CMD_MULTI:
                    begin
                        kind_next = EV_MULTI;
                        last_next = 1'b1;
                        pop       = 1'b1;
                    end
                    CMD_REL_CLICK, CMD_REL_LONG:
                    begin
                        kind_next  = EV_RELEASED;
                        last_next  = 1'b0;
                        phase_next = 1'b1;
                    end
                    default:
                    begin
                        kind_next = EV_PRESSED;
                    end
                endcase
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign evt.valid       = out_valid_reg;
    assign evt.event_kind  = kind_reg;
    assign evt.event_value = value_reg;
    assign evt.last        = last_reg;

endmodule

// File: rtl/button_click_gesture_detector_top.sv
// channel | dir | handshake     | payload
// poll    | in  | valid / ready | level, time_ms
// result  | out | valid / ready | event_kind, event_value, last
// cfg     | in  | valid / ready | index, data (0 max_gap_ms, 1 min_long_ms)
//
// A poll is taken every cycle while the command queue has room; press and
// multi-click commands leave as one result each, a release as two (released,
// then clicked or long). Commands pass through the queue and output register.
// Reset clears level, press count, queue and output; registers go to 400/600.
// A stalled result holds the output register, then the queue fills (QUEUE_DEPTH
// commands) and poll.ready drops. cfg.ready is always high.
module button_click_gesture_detector_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    bcgd_poll_if.sink    poll,
    bcgd_event_if.source result,
    bcgd_cfg_if.sink     cfg
);
    import bcgd_pkg::*;

    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      head;
    q_status_t q_status;

    bcgd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .poll     (poll),
        .cfg      (cfg),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    bcgd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    bcgd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .evt      (result)
    );

endmodule

// File: rtl/bcgd_checker.sv
module bcgd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [bcgd_pkg::KIND_W-1:0] res_kind,
    input logic [bcgd_pkg::TIME_W-1:0] res_value,
    input logic                        res_last
);
    import bcgd_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind)
            && $stable(res_value) && $stable(res_last))
        else $error("result changed while stalled");

    a_release_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != EV_RELEASED |-> res_last)
        else $error("last flag wrong");

    a_release_pair: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res_kind == EV_RELEASED
            |=> res_valid && (res_kind == EV_CLICKED || res_kind == EV_LONG))
        else $error("release not followed by click or long press");

    a_press_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == EV_PRESSED |-> res_value != '0 && res_value <= 32'd255)
        else $error("press count out of range");

endmodule

bind button_click_gesture_detector_top bcgd_checker u_bcgd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_kind  (result.event_kind),
    .res_value (result.event_value),
    .res_last  (result.last)
);

// File: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bcgd_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES = 60;
    localparam int unsigned PHASE_POLLS = 95;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] value;
        logic              last;
    } gesture_ev_t;

    typedef struct packed {
        logic              lvl;
        logic [TIME_W-1:0] tm;
        logic              typed;
        logic [1:0]        n;
        gesture_ev_t       e0;
        gesture_ev_t       e1;
    } poll_row_t;

    logic clk;
    logic rst_n;

    bcgd_poll_if  poll_ch ();
    bcgd_event_if ev_ch ();
    bcgd_cfg_if   cfg_ch ();

    button_click_gesture_detector_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .poll   (poll_ch),
        .result (ev_ch),
        .cfg    (cfg_ch)
    );

    // shadow of the detector
    logic               btn_down;
    logic [COUNT_W-1:0] presses;
    logic [TIME_W-1:0]  press_at;
    logic [TIME_W-1:0]  release_at;
    logic [CFG_W-1:0]   gap_limit;
    logic [CFG_W-1:0]   long_limit;

    gesture_ev_t due_events [$];
    poll_row_t   script [0:24];

    int unsigned sender_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned holds_asked;
    int unsigned holds_served;
    int unsigned polls_sent;
    int unsigned cfg_writes;
    int unsigned errors;
    int unsigned cycles;
    int unsigned kinds_seen [0:7];
    logic [TIME_W-1:0] now_ms;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic gesture_ev_t mk_ev(input logic [KIND_W-1:0] kind,
                                          input logic [TIME_W-1:0] value,
                                          input logic last);
        gesture_ev_t e;
        e.kind  = kind;
        e.value = value;
        e.last  = last;
        return e;
    endfunction

    function automatic int unsigned predict_gesture(input logic lvl,
                                                    input logic [TIME_W-1:0] t,
                                                    output gesture_ev_t e0,
                                                    output gesture_ev_t e1);
        logic [TIME_W-1:0] held;
        e0 = '0;
        e1 = '0;
        held = t - press_at;
        if (lvl != btn_down)
        begin
            btn_down = lvl;
            if (lvl)
            begin
                if (presses != COUNT_MAX)
                    presses = presses + 1'b1;
                press_at = t;
                e0 = mk_ev(EV_PRESSED, TIME_W'(presses), 1'b1);
                return 1;
            end
            release_at = t;
            e0 = mk_ev(EV_RELEASED, TIME_W'(presses), 1'b0);
            if (presses == COUNT_W'(1) && held >= TIME_W'(long_limit))
            begin
                e1 = mk_ev(EV_LONG, held, 1'b1);
                presses = '0;
            end
            else
                e1 = mk_ev(EV_CLICKED, TIME_W'(presses), 1'b1);
            return 2;
        end
        if (!btn_down && presses != '0 && (t - release_at) >= TIME_W'(gap_limit))
        begin
            e0 = mk_ev(EV_MULTI, TIME_W'(presses), 1'b1);
            presses = '0;
            return 1;
        end
        return 0;
    endfunction

    function automatic void flag(input string what, input logic [TIME_W-1:0] want,
                                 input logic [TIME_W-1:0] got);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected %0h, got %0h", what, want, got);
    endfunction

    task automatic send_poll(input logic lvl, input logic [TIME_W-1:0] t, input logic typed,
                             input logic [1:0] n_typed, input gesture_ev_t t0,
                             input gesture_ev_t t1);
        gesture_ev_t p0;
        gesture_ev_t p1;
        int unsigned n;
        int unsigned gap;
        poll_ch.valid   <= 1'b1;
        poll_ch.level   <= lvl;
        poll_ch.time_ms <= t;
        do
            @(posedge clk);
        while (!poll_ch.ready);
        polls_sent++;
        n = predict_gesture(lvl, t, p0, p1);
        if (typed)
        begin
            n  = n_typed;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0)
            due_events.push_back(p0);
        if (n > 1)
            due_events.push_back(p1);
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap != 0)
        begin
            poll_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_level(input logic lvl, input logic [TIME_W-1:0] t);
        send_poll(lvl, t, 1'b0, 2'd0, '0, '0);
        now_ms = t;
    endtask

    task automatic wait_drained();
        poll_ch.valid <= 1'b0;
        while (due_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_writes++;
        if (idx == REG_MAX_GAP)
            gap_limit = data;
        else
            long_limit = data;
    endtask

    task automatic set_limits(input logic [CFG_W-1:0] gap, input logic [CFG_W-1:0] long_ms);
        wait_drained();
        write_reg(REG_MAX_GAP, gap);
        write_reg(REG_MIN_LONG, long_ms);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_idle(input int unsigned mode);
        case (mode)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin sender_idle_pct = 37; recv_stall_pct = 37; end
        endcase
    endtask

    function automatic logic [TIME_W-1:0] pick_span(input logic [CFG_W-1:0] limit);
        logic [TIME_W-1:0] lim;
        lim = TIME_W'(limit);
        case ($urandom_range(5))
            0: return lim - 1;
            1: return lim;
            2: return lim + 1;
            3: return $urandom_range(lim);
            4: return lim + $urandom_range(2 * lim + 10);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_gesture();
        int unsigned clicks;
        int unsigned k;
        logic [TIME_W-1:0] hold;
        logic [TIME_W-1:0] pause;
        logic [TIME_W-1:0] rel_t;
        if ($urandom_range(7) == 0)
            now_ms = $urandom;
        clicks = ($urandom_range(5) == 0) ? 1 : $urandom_range(1, 4);
        rel_t = now_ms;
        for (k = 0; k < clicks; k++)
        begin
            send_level(1'b1, now_ms + $urandom_range(3));
            hold = pick_span(long_limit);
            if ($urandom_range(3) == 0)
                send_level(1'b1, now_ms + hold / 2);
            rel_t = press_at + hold;
            send_level(1'b0, rel_t);
            if (k + 1 < clicks)
            begin
                pause = (gap_limit != '0) ? $urandom_range(gap_limit - 1) : '0;
                if (gap_limit != '0 && $urandom_range(1) == 0)
                    send_level(1'b0, rel_t + pause / 2);
                now_ms = rel_t + pause;
            end
        end
        pause = pick_span(gap_limit);
        send_level(1'b0, rel_t + pause);
        if ($urandom_range(2) == 0)
            send_level(1'b0, rel_t + pause + $urandom_range(gap_limit));
    endtask

    task automatic run_phase(input int unsigned target);
        int unsigned start;
        start = polls_sent;
        while (polls_sent - start < target)
        begin
            if ($urandom_range(9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_level(1'($urandom_range(1)), $urandom);
            end
            else
                run_gesture();
            if ($urandom_range(29) == 0)
                wait_drained();
        end
    endtask

    // receiver: random stalls, plus long hold-offs on request
    initial
    begin
        ev_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                ev_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            ev_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        gesture_ev_t want;
        if (rst_n && ev_ch.valid && ev_ch.ready)
        begin
            kinds_seen[ev_ch.event_kind]++;
            if (due_events.size() == 0)
                flag("result with nothing due, kind", '0, TIME_W'(ev_ch.event_kind));
            else
            begin
                want = due_events.pop_front();
                if (ev_ch.event_kind !== want.kind)
                    flag("event_kind", TIME_W'(want.kind), TIME_W'(ev_ch.event_kind));
                if (ev_ch.event_value !== want.value)
                    flag("event_value", want.value, ev_ch.event_value);
                if (ev_ch.last !== want.last)
                    flag("last", TIME_W'(want.last), TIME_W'(ev_ch.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        int unsigned i;
        int unsigned p;
        rst_n           <= 1'b0;
        poll_ch.valid   <= 1'b0;
        poll_ch.level   <= 1'b0;
        poll_ch.time_ms <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_MAX_GAP;
        cfg_ch.data     <= '0;
        errors = 0;
        polls_sent = 0;
        cfg_writes = 0;
        holds_asked = 0;
        holds_served = 0;
        for (i = 0; i < 8; i++)
            kinds_seen[i] = 0;
        btn_down   = 1'b0;
        presses    = '0;
        press_at   = '0;
        release_at = '0;
        gap_limit  = MAX_GAP_RESET;
        long_limit = MIN_LONG_RESET;
        set_idle(0);

        script = '{
            '{1'b0, 32'd0,          1'b1, 2'd0, '0, '0},
            '{1'b1, 32'd100,        1'b1, 2'd1, mk_ev(EV_PRESSED, 32'd1, 1'b1), '0},
            '{1'b1, 32'd150,        1'b1, 2'd0, '0, '0},
            '{1'b0, 32'd200,        1'b1, 2'd2, mk_ev(EV_RELEASED, 32'd1, 1'b0),
                                                mk_ev(EV_CLICKED, 32'd1, 1'b1)},
            '{1'b0, 32'd599,        1'b0, 2'd0, '0, '0},
            '{1'b0, 32'd600,        1'b0, 2'd0, '0, '0},
            '{1'b1, 32'd1000,       1'b0, 2'd0, '0, '0},
            '{1'b0, 32'd1600,       1'b0, 2'd0, '0, '0},
            '{1'b1, 32'd2000,       1'b0, 2'd0, '0, '0},
            '{1'b0, 32'd2599,       1'b0, 2'd0, '0, '0},
            '{1'b1, 32'd2700,       1'b0, 2'd0, '0, '0},
            '{1'b0, 32'd2800,       1'b0, 2'd0, '0, '0},
            '{1'b1, 32'd2900,       1'b0, 2'd0, '0, '0},
            '{1'b0, 32'd4000,       1'b0, 2'd0, '0, '0},
            '{1'b0, 32'd4400,       1'b0, 2'd0, '0, '0},
            '{1'b1, 32'hFFFF_FF00,  1'b0, 2'd0, '0, '0},
            '{1'b0, 32'h0000_0010,  1'b0, 2'd0, '0, '0},
            '{1'b0, 32'hFFFF_FFFF,  1'b0, 2'd0, '0, '0},
            '{1'b1, 32'h8000_0000,  1'b0, 2'd0, '0, '0},
            '{1'b0, 32'h7FFF_FFFF,  1'b1, 2'd2, mk_ev(EV_RELEASED, 32'd1, 1'b0),
                                                mk_ev(EV_LONG, 32'hFFFF_FFFF, 1'b1)},
            '{1'b0, 32'h7FFF_FFFF,  1'b1, 2'd0, '0, '0},
            '{1'b1, 32'hFFFF_FFFF,  1'b0, 2'd0, '0, '0},
            '{1'b1, 32'd0,          1'b0, 2'd0, '0, '0},
            '{1'b0, 32'hFFFF_FFFF,  1'b0, 2'd0, '0, '0},
            '{1'b0, 32'd0,          1'b0, 2'd0, '0, '0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < 25; i++)
            send_poll(script[i].lvl, script[i].tm, script[i].typed, script[i].n,
                      script[i].e0, script[i].e1);
        now_ms = script[24].tm;

        // press count runs into saturation while the receiver holds off
        holds_asked++;
        for (i = 0; i < 258; i++)
        begin
            send_level(1'b1, now_ms + 1);
            send_level(1'b0, now_ms + 1);
        end
        send_level(1'b0, now_ms + TIME_W'(gap_limit));
        wait_drained();

        for (p = 0; p < 6; p++)
        begin
            case (p)
                1: set_limits('0, '0);
                2: set_limits('1, '1);
                3: set_limits(CFG_W'($urandom_range(16'hFFFF)),
                              CFG_W'($urandom_range(16'hFFFF)));
                4: set_limits(CFG_W'($urandom_range(1, 50)), CFG_W'($urandom_range(1, 80)));
                5: set_limits(MAX_GAP_RESET, MIN_LONG_RESET);
                default: ;
            endcase
            set_idle(p % 4);
            if (p == 3)
                holds_asked++;
            run_phase(PHASE_POLLS);
        end

        wait_drained();
        $display("summary: %0d polls, %0d register writes, %0d mismatches",
                 polls_sent, cfg_writes, errors);
        $display("summary: pressed %0d, released %0d, clicked %0d, multi %0d, long %0d",
                 kinds_seen[EV_PRESSED], kinds_seen[EV_RELEASED], kinds_seen[EV_CLICKED],
                 kinds_seen[EV_MULTI], kinds_seen[EV_LONG]);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
